// ===== src/cau_pkg.sv =====
`timescale 1ns / 1ps

package cau_pkg;

  localparam logic [2:0] OP_EQ  = 3'd0;
  localparam logic [2:0] OP_ADD = 3'd1;
  localparam logic [2:0] OP_SUB = 3'd2;
  localparam logic [2:0] OP_MUL = 3'd3;
  localparam logic [2:0] OP_DIV = 3'd4;

  localparam logic [1:0] ST_OK  = 2'd0;
  localparam logic [1:0] ST_SAT = 2'd1;
  localparam logic [1:0] ST_DZ  = 2'd2;

endpackage

// ===== src/complex_arith_unit.sv =====
`timescale 1ns / 1ps

// Channel  | Handshake          | Payload
// in       | in_valid/in_ready  | operation, a_re, a_im, b_re, b_im
// out      | out_valid/out_ready| res_re, res_im, is_equal, status
//
// Fully pipelined: one transfer per cycle on each side when not stalled.
// DATA_WIDTH + 5 register stages: input, products, sums, divider setup,
// DATA_WIDTH restoring divider stages (one quotient bit each) and the output
// register. All stages advance together whenever the output register is
// empty or being drained. Synchronous reset clears valid bits.
module complex_arith_unit #(
  parameter int DATA_WIDTH = 16,
  parameter int FRAC_BITS  = 8
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [2:0]                   operation,
  input  logic signed [DATA_WIDTH-1:0] a_re,
  input  logic signed [DATA_WIDTH-1:0] a_im,
  input  logic signed [DATA_WIDTH-1:0] b_re,
  input  logic signed [DATA_WIDTH-1:0] b_im,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [DATA_WIDTH-1:0] res_re,
  output logic signed [DATA_WIDTH-1:0] res_im,
  output logic                         is_equal,
  output logic [1:0]                   status
);
  import cau_pkg::*;

  localparam int W  = DATA_WIDTH;
  localparam int F  = FRAC_BITS;
  localparam int PW = 2 * W;
  localparam int SW = 2 * W + 1;
  localparam int DW = 2 * W;
  localparam int RW = 3 * W + F + 1;

  typedef struct packed {
    logic          valid;
    logic [2:0]    op;
    logic          eq;
    logic [W-1:0]  rre;
    logic [W-1:0]  rim;
    logic          sat;
    logic          dz;
    logic          neg_re;
    logic          neg_im;
    logic          ovf_re;
    logic          ovf_im;
    logic [RW-1:0] rem_re;
    logic [RW-1:0] rem_im;
    logic [W-1:0]  q_re;
    logic [W-1:0]  q_im;
    logic [DW-1:0] den;
  } dstage_t;

  function automatic logic [W:0] sat_fn(input logic neg, input logic [RW-1:0] mag);
    logic [RW-1:0] maxp;
    logic [RW-1:0] maxn;
    logic [W-1:0]  low;
    maxp = {{(RW-W+1){1'b0}}, {(W-1){1'b1}}};
    maxn = {{(RW-W){1'b0}}, 1'b1, {(W-1){1'b0}}};
    low  = mag[W-1:0];
    if (!neg) begin
      if (mag > maxp) sat_fn = {1'b1, 1'b0, {(W-1){1'b1}}};
      else            sat_fn = {1'b0, low};
    end else begin
      if (mag > maxn) sat_fn = {1'b1, 1'b1, {(W-1){1'b0}}};
      else            sat_fn = {1'b0, W'(-low)};
    end
  endfunction

  function automatic logic [RW-1:0] abs_fn(input logic signed [SW-1:0] s);
    logic [SW-1:0] m;
    m = s[SW-1] ? SW'(-s) : SW'(s);
    abs_fn = RW'(m);
  endfunction

  logic en;
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  // stage 1: input register
  logic                v1;
  logic [2:0]          op1;
  logic signed [W-1:0] ar1, ai1, br1, bi1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
    end
    if (en) begin
      op1 <= operation;
      ar1 <= a_re;
      ai1 <= a_im;
      br1 <= b_re;
      bi1 <= b_im;
    end
  end

  // stage 2: products, add/sub, compare
  logic                 v2;
  logic [2:0]           op2;
  logic signed [PW-1:0] p_rr, p_ii, p_ri, p_ir, p_br, p_bi;
  logic [W-1:0]         as_re2, as_im2;
  logic                 as_sat2, eq2;

  logic signed [W:0] sa_re, sa_im;
  logic [W:0]        sv_re, sv_im;
  always_comb begin
    if (op1 == OP_SUB) begin
      sa_re = (W+1)'(ar1) - (W+1)'(br1);
      sa_im = (W+1)'(ai1) - (W+1)'(bi1);
    end else begin
      sa_re = (W+1)'(ar1) + (W+1)'(br1);
      sa_im = (W+1)'(ai1) + (W+1)'(bi1);
    end
    sv_re = sat_fn(sa_re[W], abs_fn(SW'(sa_re)));
    sv_im = sat_fn(sa_im[W], abs_fn(SW'(sa_im)));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
    if (en) begin
      op2     <= op1;
      p_rr    <= PW'(ar1) * PW'(br1);
      p_ii    <= PW'(ai1) * PW'(bi1);
      p_ri    <= PW'(ar1) * PW'(bi1);
      p_ir    <= PW'(ai1) * PW'(br1);
      p_br    <= PW'(br1) * PW'(br1);
      p_bi    <= PW'(bi1) * PW'(bi1);
      as_re2  <= sv_re[W-1:0];
      as_im2  <= sv_im[W-1:0];
      as_sat2 <= sv_re[W] | sv_im[W];
      eq2     <= (ar1 == br1) && (ai1 == bi1);
    end
  end

  // stage 3: sums of products
  logic                 v3;
  logic [2:0]           op3;
  logic signed [SW-1:0] m_re3, m_im3, d_re3, d_im3;
  logic [DW-1:0]        den3;
  logic [W-1:0]         as_re3, as_im3;
  logic                 as_sat3, eq3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= v2;
    end
    if (en) begin
      op3     <= op2;
      m_re3   <= SW'(p_rr) - SW'(p_ii);
      m_im3   <= SW'(p_ri) + SW'(p_ir);
      d_re3   <= SW'(p_rr) + SW'(p_ii);
      d_im3   <= SW'(p_ir) - SW'(p_ri);
      den3    <= DW'(p_br) + DW'(p_bi);
      as_re3  <= as_re2;
      as_im3  <= as_im2;
      as_sat3 <= as_sat2;
      eq3     <= eq2;
    end
  end

  // stage 4: scale products, set up the divider
  dstage_t pipe [0:W];
  dstage_t entry;

  logic [RW-1:0] mm_re, mm_im, sc_re, sc_im, n_re, n_im, den_top;
  logic [W:0]    ms_re, ms_im;
  logic          mn_re, mn_im;

  always_comb begin
    mn_re   = m_re3[SW-1];
    mn_im   = m_im3[SW-1];
    mm_re   = abs_fn(m_re3);
    mm_im   = abs_fn(m_im3);
    // floor toward minus infinity on sign-magnitude
    sc_re   = mn_re ? ((mm_re + RW'((RW'(1) << F) - RW'(1))) >> F) : (mm_re >> F);
    sc_im   = mn_im ? ((mm_im + RW'((RW'(1) << F) - RW'(1))) >> F) : (mm_im >> F);
    ms_re   = sat_fn(mn_re && (sc_re != '0), sc_re);
    ms_im   = sat_fn(mn_im && (sc_im != '0), sc_im);
    n_re    = abs_fn(d_re3) << F;
    n_im    = abs_fn(d_im3) << F;
    den_top = RW'(den3) << W;

    entry        = '0;
    entry.valid  = v3;
    entry.op     = op3;
    entry.den    = den3;
    entry.dz     = (den3 == '0);
    entry.neg_re = d_re3[SW-1];
    entry.neg_im = d_im3[SW-1];
    entry.ovf_re = (n_re >= den_top);
    entry.ovf_im = (n_im >= den_top);
    entry.rem_re = n_re;
    entry.rem_im = n_im;
    case (op3)
      OP_EQ: begin
        entry.eq = eq3;
      end
      OP_ADD, OP_SUB: begin
        entry.rre = as_re3;
        entry.rim = as_im3;
        entry.sat = as_sat3;
      end
      OP_MUL: begin
        entry.rre = ms_re[W-1:0];
        entry.rim = ms_im[W-1:0];
        entry.sat = ms_re[W] | ms_im[W];
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pipe[W].valid <= 1'b0;
    end else if (en) begin
      pipe[W].valid <= entry.valid;
    end
    if (en) begin
      pipe[W][$bits(dstage_t)-2:0] <= entry[$bits(dstage_t)-2:0];
    end
  end

  // divider: stage k resolves quotient bit k
  for (genvar k = W - 1; k >= 0; k--) begin : g_div
    dstage_t nx;
    logic [RW-1:0] dsh;
    always_comb begin
      nx  = pipe[k+1];
      dsh = RW'(pipe[k+1].den) << k;
      if (pipe[k+1].rem_re >= dsh) begin
        nx.rem_re  = pipe[k+1].rem_re - dsh;
        nx.q_re[k] = 1'b1;
      end
      if (pipe[k+1].rem_im >= dsh) begin
        nx.rem_im  = pipe[k+1].rem_im - dsh;
        nx.q_im[k] = 1'b1;
      end
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        pipe[k].valid <= 1'b0;
      end else if (en) begin
        pipe[k].valid <= nx.valid;
      end
      if (en) begin
        pipe[k][$bits(dstage_t)-2:0] <= nx[$bits(dstage_t)-2:0];
      end
    end
  end

  // final stage: sign and saturate quotients, output register
  logic [RW-1:0] qm_re, qm_im;
  logic [W:0]    qs_re, qs_im;
  logic [W-1:0]  res_re_next, res_im_next;
  logic [1:0]    status_next;
  logic          sat_f;

  always_comb begin
    qm_re = pipe[0].ovf_re ? (RW'(1) << W) : RW'(pipe[0].q_re);
    qm_im = pipe[0].ovf_im ? (RW'(1) << W) : RW'(pipe[0].q_im);
    qs_re = sat_fn(pipe[0].neg_re && (qm_re != '0), qm_re);
    qs_im = sat_fn(pipe[0].neg_im && (qm_im != '0), qm_im);
    res_re_next = pipe[0].rre;
    res_im_next = pipe[0].rim;
    sat_f       = pipe[0].sat;
    status_next = ST_OK;
    if (pipe[0].op == OP_DIV) begin
      if (pipe[0].dz) begin
        res_re_next = '0;
        res_im_next = '0;
        sat_f       = 1'b0;
        status_next = ST_DZ;
      end else begin
        res_re_next = qs_re[W-1:0];
        res_im_next = qs_im[W-1:0];
        sat_f       = qs_re[W] | qs_im[W];
      end
    end
    if (sat_f) status_next = ST_SAT;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= pipe[0].valid;
    end
    if (en) begin
      res_re   <= res_re_next;
      res_im   <= res_im_next;
      is_equal <= pipe[0].eq;
      status   <= status_next;
    end
  end

  a_zero_div: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == ST_DZ) |-> (res_re == '0 && res_im == '0 && !is_equal))
    else $error("division by zero result not cleared");

  a_eq_clean: assert property (@(posedge clk) disable iff (rst)
    (out_valid && is_equal) |-> (status == ST_OK && res_re == '0 && res_im == '0))
    else $error("equality result carries arithmetic data");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (status == ST_OK || status == ST_SAT || status == ST_DZ))
    else $error("bad status code");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(status) && $stable(res_re)))
    else $error("stalled result changed");

endmodule
